// ----- src/ndl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_pkg: shared types and constants of the index linearizer
// Widths, operation and status codes, register indexes, and the end-position
// test used by the odometer and the report logic.
// ----------------------------------------------------------------------------
package ndl_pkg;

  // Array geometry
  localparam int MAX_AXES    = 4;
  localparam int AXIS_BITS   = 16;
  localparam int OFFSET_BITS = 32;

  // Port field widths
  localparam int FIELD_AXES = 4;
  localparam int OP_W       = 3;
  localparam int COORD_W    = 16;
  localparam int LOFF_W     = 32;
  localparam int OUT_OFF_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 3;

  // Derived widths
  localparam int IDX_W  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int CNT_W  = $clog2(MAX_AXES + 1);
  localparam int SAT_W  = OFFSET_BITS + 1;
  localparam int PROD_W = OFFSET_BITS + AXIS_BITS;
  localparam int DSH_W  = OFFSET_BITS + AXIS_BITS - 1;
  localparam int J_W    = $clog2(AXIS_BITS);

  // Saturated value: anything at or above 2**OFFSET_BITS
  localparam logic [SAT_W-1:0] SAT_VAL = {1'b1, {OFFSET_BITS{1'b0}}};

  // Operation codes
  localparam logic [OP_W-1:0] OP_TO_OFFSET = 3'd0;
  localparam logic [OP_W-1:0] OP_TO_COORD  = 3'd1;
  localparam logic [OP_W-1:0] OP_BEGIN     = 3'd2;
  localparam logic [OP_W-1:0] OP_FWD       = 3'd3;
  localparam logic [OP_W-1:0] OP_BACK      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_END    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEFORE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SIZE_0 = 3'd1;

  typedef logic [MAX_AXES-1:0][AXIS_BITS-1:0] pos_t;

  // Decoded view of the configuration registers
  typedef struct packed {
    logic [CNT_W-1:0]    n;
    logic [IDX_W-1:0]    last;
    logic [MAX_AXES-1:0] in_use;
    logic                any_zero;
    pos_t                size;
    pos_t                end_pos;
  } cfg_view_t;

  function automatic logic at_end(pos_t pos, cfg_view_t cv);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < MAX_AXES; i++) begin
      if (cv.in_use[i] && (pos[i] != cv.end_pos[i])) hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

// ----- src/ndl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_if: channel interfaces of the index linearizer
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface ndl_item_if import ndl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  coord_0;
  logic [COORD_W-1:0]  coord_1;
  logic [COORD_W-1:0]  coord_2;
  logic [COORD_W-1:0]  coord_3;
  logic [LOFF_W-1:0]   linear_offset;

  modport source (output valid, op, coord_0, coord_1, coord_2, coord_3, linear_offset,
                  input ready);
  modport sink   (input valid, op, coord_0, coord_1, coord_2, coord_3, linear_offset,
                  output ready);
endinterface

interface ndl_result_if import ndl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_OFF_W-1:0] out_offset;
  logic [COORD_W-1:0]   out_coord_0;
  logic [COORD_W-1:0]   out_coord_1;
  logic [COORD_W-1:0]   out_coord_2;
  logic [COORD_W-1:0]   out_coord_3;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, out_offset, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, status, input ready);
  modport sink   (input valid, out_offset, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, status, output ready);
endinterface

interface ndl_cfg_if import ndl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ndl_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_cfg: configuration registers
// Holds axis count and sizes and decodes axes in use, end position and the
// empty-array flag.
// ----------------------------------------------------------------------------
module ndl_cfg import ndl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ndl_cfg_if.sink   cfg,
  output cfg_view_t cv
);

  logic [COUNT_W-1:0] axis_count;
  pos_t               axis_size;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= COUNT_W'(1);
      for (int i = 0; i < MAX_AXES; i++) axis_size[i] <= AXIS_BITS'(1);
    end else if (cfg.valid) begin
      if (cfg.index == REG_AXIS_COUNT) axis_count <= cfg.data[COUNT_W-1:0];
      for (int i = 0; i < MAX_AXES; i++) begin
        if (int'(cfg.index) == int'(REG_AXIS_SIZE_0) + i) begin
          axis_size[i] <= AXIS_BITS'(cfg.data);
        end
      end
    end
  end

  always_comb begin
    cv = '0;
    if (axis_count == '0)               cv.n = CNT_W'(1);
    else if (int'(axis_count) > MAX_AXES) cv.n = CNT_W'(MAX_AXES);
    else                                cv.n = CNT_W'(axis_count);
    cv.last = IDX_W'(cv.n - CNT_W'(1));
    cv.size = axis_size;
    for (int i = 0; i < MAX_AXES; i++) begin
      cv.in_use[i] = (i < int'(cv.n));
      if (cv.in_use[i] && (axis_size[i] == '0)) cv.any_zero = 1'b1;
      if (IDX_W'(i) == cv.last)     cv.end_pos[i] = axis_size[i];
      else if (axis_size[i] != '0)  cv.end_pos[i] = axis_size[i] - AXIS_BITS'(1);
      else                          cv.end_pos[i] = '0;
    end
  end

endmodule

// ----- src/ndl_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_mul: shared saturating multiplier
// Multiplies a saturated stride operand by an axis value, clamping
// results at or above 2**OFFSET_BITS to the saturated value.
// ----------------------------------------------------------------------------
module ndl_mul import ndl_pkg::*; (
  input  logic [SAT_W-1:0]     a,
  input  logic [AXIS_BITS-1:0] b,
  output logic [SAT_W-1:0]     y
);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(a[OFFSET_BITS-1:0]) * PROD_W'(b);

  always_comb begin
    if (b == '0)                          y = '0;
    else if (a[OFFSET_BITS])              y = SAT_VAL;
    else if (prod[PROD_W-1:OFFSET_BITS] != '0) y = SAT_VAL;
    else                                  y = {1'b0, prod[OFFSET_BITS-1:0]};
  end

endmodule

// ----- src/ndl_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_div_step: one restoring division step
// Compares the remainder with the shifted stride and subtracts on a hit.
// ----------------------------------------------------------------------------
module ndl_div_step import ndl_pkg::*; (
  input  logic [OFFSET_BITS-1:0] rest,
  input  logic [DSH_W-1:0]       dsh,
  input  logic                   big,
  output logic                   ge,
  output logic [OFFSET_BITS-1:0] rest_next
);

  assign ge        = !big && (DSH_W'(rest) >= dsh);
  assign rest_next = ge ? (rest - dsh[OFFSET_BITS-1:0]) : rest;

endmodule

// ----- src/ndl_odo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_odo: odometer position update
// Next stored position for begin, step forward and step back.
// ----------------------------------------------------------------------------
module ndl_odo import ndl_pkg::*; (
  input  cfg_view_t       cv,
  input  logic [OP_W-1:0] op,
  input  pos_t            pos,
  output pos_t            pos_next,
  output logic            underflow
);

  always_comb begin
    logic                 cy;
    logic                 bw;
    logic [AXIS_BITS-1:0] inc;
    pos_t                 t;
    pos_next  = pos;
    underflow = 1'b0;
    cy        = 1'b1;
    bw        = 1'b1;
    inc       = '0;
    t         = pos;
    case (op)
      OP_BEGIN: begin
        pos_next = '0;
        if (cv.any_zero) begin
          for (int i = 0; i < MAX_AXES; i++) if (cv.in_use[i]) pos_next[i] = cv.end_pos[i];
        end
      end
      OP_FWD: begin
        if (cv.any_zero || at_end(pos, cv)) begin
          for (int i = 0; i < MAX_AXES; i++) if (cv.in_use[i]) pos_next[i] = cv.end_pos[i];
        end else begin
          // ripple the carry outward from the innermost axis in use
          for (int a = MAX_AXES - 1; a >= 0; a--) begin
            if (cv.in_use[a] && cy) begin
              inc = pos_next[a] + AXIS_BITS'(1);
              if (inc == cv.size[a]) begin
                pos_next[a] = '0;
              end else begin
                pos_next[a] = inc;
                cy = 1'b0;
              end
            end
          end
          // a carry out of the outermost axis lands on the end position
          if (cy) begin
            for (int i = 0; i < MAX_AXES; i++) if (cv.in_use[i]) pos_next[i] = cv.end_pos[i];
          end
        end
      end
      OP_BACK: begin
        if (cv.any_zero) begin
          underflow = 1'b1;
        end else begin
          for (int a = MAX_AXES - 1; a >= 0; a--) begin
            if (cv.in_use[a] && bw) begin
              if (t[a] != '0) begin
                t[a] = t[a] - AXIS_BITS'(1);
                bw = 1'b0;
              end else begin
                t[a] = cv.size[a] - AXIS_BITS'(1);
              end
            end
          end
          if (bw) underflow = 1'b1;
          else    pos_next  = t;
        end
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

endmodule

// ----- src/nd_index_linearizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_index_linearizer: row-major index engine for up to four axes
// Offset from coordinates, coordinates from offset, and a stored odometer.
// ----------------------------------------------------------------------------
// One item is worked at a time; item.ready is high only while the sequencer
// is idle, and a finished result waits in the output register so the next
// item can transfer meanwhile. An offset request passes S_LIN_MUL and
// S_LIN_ACC for each axis in use (after S_UPD for an odometer request); a
// coordinate request runs S_STRIDE per axis, S_CHECK, then S_DIV_LOAD and
// S_DIV per axis, ending after S_CHECK when the offset is out of range.
// One shared saturating multiplier serves each stride and term, and the
// divider resolves one quotient bit per cycle for each axis. Register writes
// are taken in any cycle but must only be issued while the block is idle;
// they never move the stored position. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module nd_index_linearizer import ndl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ndl_item_if.sink    item,
  ndl_result_if.source result,
  ndl_cfg_if.sink     cfg
);

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STATE_W-1:0] S_UPD      = 4'd1;
  localparam logic [STATE_W-1:0] S_LIN_MUL  = 4'd2;
  localparam logic [STATE_W-1:0] S_LIN_ACC  = 4'd3;
  localparam logic [STATE_W-1:0] S_STRIDE   = 4'd4;
  localparam logic [STATE_W-1:0] S_CHECK    = 4'd5;
  localparam logic [STATE_W-1:0] S_DIV_LOAD = 4'd6;
  localparam logic [STATE_W-1:0] S_DIV      = 4'd7;
  localparam logic [STATE_W-1:0] S_DONE     = 4'd8;

  cfg_view_t cv;

  logic [STATE_W-1:0]     state;
  logic [OP_W-1:0]        op_r;
  logic [OFFSET_BITS-1:0] given_r;
  pos_t                   c_r;
  pos_t                   position;
  logic [IDX_W-1:0]       k;
  logic [SAT_W-1:0]       stride_r;
  logic [SAT_W-1:0]       prod_r;
  logic [SAT_W-1:0]       sum_r;
  logic                   bad_r;
  logic                   under_r;
  logic                   range_r;
  logic [SAT_W-1:0]       strd [MAX_AXES];
  logic [OFFSET_BITS-1:0] rest_r;
  logic [DSH_W-1:0]       dsh_r;
  logic                   dbig_r;
  logic [AXIS_BITS-1:0]   q_r;
  logic [J_W-1:0]         j;

  // output register
  logic                   res_valid;
  logic [OUT_OFF_W-1:0]   res_off;
  pos_t                   res_c;
  logic [STATUS_W-1:0]    res_status;

  logic [AXIS_BITS-1:0]   mul_b;
  logic [SAT_W-1:0]       mul_y;
  logic                   div_ge;
  logic [OFFSET_BITS-1:0] div_rest;
  logic [AXIS_BITS-1:0]   q_next;
  pos_t                   pos_next;
  pos_t                   pos_use;
  logic                   underflow;
  logic [SAT_W:0]         sum_add;
  logic [SAT_W-1:0]       sum_next;
  logic [FIELD_AXES-1:0][COORD_W-1:0] in_fields;
  logic [FIELD_AXES-1:0][COORD_W-1:0] out_fields;
  pos_t                   in_c;
  logic                   lin_bad;
  logic [OFFSET_BITS-1:0] done_off;
  logic [STATUS_W-1:0]    done_status;
  logic                   out_free;

  ndl_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cv  (cv)
  );

  // the multiplier takes a coordinate when forming a term, a size otherwise
  assign mul_b = (state == S_LIN_MUL) ? c_r[k] : cv.size[k];

  ndl_mul u_mul (
    .a (stride_r),
    .b (mul_b),
    .y (mul_y)
  );

  ndl_div_step u_div (
    .rest      (rest_r),
    .dsh       (dsh_r),
    .big       (dbig_r),
    .ge        (div_ge),
    .rest_next (div_rest)
  );

  ndl_odo u_odo (
    .cv        (cv),
    .op        (op_r),
    .pos       (position),
    .pos_next  (pos_next),
    .underflow (underflow)
  );

  assign q_next = {q_r[AXIS_BITS-2:0], div_ge};

  // saturating accumulate of the registered term
  assign sum_add  = {1'b0, sum_r} + {1'b0, prod_r};
  assign sum_next = (sum_add[SAT_W] | sum_add[SAT_W-1]) ? SAT_VAL : sum_add[SAT_W-1:0];

  assign in_fields = {item.coord_3, item.coord_2, item.coord_1, item.coord_0};

  // drop coordinates of axes not in use
  always_comb begin
    for (int i = 0; i < MAX_AXES; i++) begin
      if (cv.in_use[i] && (i < FIELD_AXES)) in_c[i] = AXIS_BITS'(in_fields[i % FIELD_AXES]);
      else                                  in_c[i] = '0;
      pos_use[i] = cv.in_use[i] ? pos_next[i] : '0;
    end
  end

  // result of the finished item
  assign lin_bad = bad_r | sum_r[OFFSET_BITS];

  always_comb begin
    done_off    = lin_bad ? '0 : sum_r[OFFSET_BITS-1:0];
    done_status = ST_OK;
    case (op_r)
      OP_TO_OFFSET: begin
        done_status = lin_bad ? ST_RANGE : ST_OK;
      end
      OP_TO_COORD: begin
        done_off    = given_r;
        done_status = range_r ? ST_RANGE : ST_OK;
      end
      default: begin
        if (under_r)                 done_status = ST_BEFORE;
        else if (lin_bad)            done_status = ST_RANGE;
        else if (at_end(position, cv)) done_status = ST_END;
        else                         done_status = ST_OK;
      end
    endcase
  end

  assign out_free   = !res_valid || result.ready;
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      position  <= '0;
    end else begin
      // in S_DONE the load below owns res_valid
      if (result.valid && result.ready && (state != S_DONE)) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            op_r     <= item.op;
            given_r  <= OFFSET_BITS'(item.linear_offset);
            c_r      <= (item.op == OP_TO_OFFSET) ? in_c : '0;
            stride_r <= SAT_W'(1);
            sum_r    <= '0;
            bad_r    <= 1'b0;
            under_r  <= 1'b0;
            range_r  <= 1'b0;
            k        <= cv.last;
            if (item.op == OP_TO_OFFSET)     state <= S_LIN_MUL;
            else if (item.op == OP_TO_COORD) state <= S_STRIDE;
            else                             state <= S_UPD;
          end
        end
        S_UPD: begin
          // advance the odometer, then report its offset
          position <= pos_next;
          c_r      <= pos_use;
          under_r  <= underflow;
          state    <= S_LIN_MUL;
        end
        S_LIN_MUL: begin
          prod_r <= mul_y;
          if (c_r[k] > cv.size[k]) bad_r <= 1'b1;
          state <= S_LIN_ACC;
        end
        S_LIN_ACC: begin
          sum_r    <= sum_next;
          stride_r <= mul_y;
          if (k == '0) begin
            state <= S_DONE;
          end else begin
            k     <= k - IDX_W'(1);
            state <= S_LIN_MUL;
          end
        end
        S_STRIDE: begin
          // hold each axis stride; the final product is the entry count
          strd[k]  <= stride_r;
          stride_r <= mul_y;
          if (k == '0) state <= S_CHECK;
          else         k <= k - IDX_W'(1);
        end
        S_CHECK: begin
          rest_r <= given_r;
          k      <= '0;
          if ({1'b0, given_r} >= stride_r) begin
            range_r <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          dbig_r <= strd[k][OFFSET_BITS];
          dsh_r  <= {strd[k][OFFSET_BITS-1:0], {(AXIS_BITS-1){1'b0}}};
          q_r    <= '0;
          j      <= J_W'(AXIS_BITS - 1);
          state  <= S_DIV;
        end
        S_DIV: begin
          rest_r <= div_rest;
          dsh_r  <= dsh_r >> 1;
          q_r    <= q_next;
          if (j == '0) begin
            c_r[k] <= q_next;
            if (k == cv.last) begin
              state <= S_DONE;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_DIV_LOAD;
            end
          end else begin
            j <= j - J_W'(1);
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            res_valid  <= 1'b1;
            res_off    <= OUT_OFF_W'(done_off);
            res_c      <= c_r;
            res_status <= done_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FIELD_AXES; i++) begin
      if (i < MAX_AXES) out_fields[i] = COORD_W'(res_c[i % MAX_AXES]);
      else              out_fields[i] = '0;
    end
  end

  assign result.valid       = res_valid;
  assign result.out_offset  = res_off;
  assign result.out_coord_0 = out_fields[0];
  assign result.out_coord_1 = out_fields[1];
  assign result.out_coord_2 = out_fields[2];
  assign result.out_coord_3 = out_fields[3];
  assign result.status      = res_status;

endmodule

// ----- src/ndl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndl_checker: port-level checks of the index linearizer
// Watches the item and result channels and tracks items in flight.
// ----------------------------------------------------------------------------
module ndl_checker import ndl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_OFF_W-1:0] out_offset,
  input logic [COORD_W-1:0]   out_coord_0,
  input logic [COORD_W-1:0]   out_coord_1,
  input logic [COORD_W-1:0]   out_coord_2,
  input logic [COORD_W-1:0]   out_coord_3,
  input logic [STATUS_W-1:0]  status
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else     pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
  end

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("item channel ready right after a transfer");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 2'd0))
    else $error("result offered with no item in flight");

  a_not_same_cycle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_xfer))
    else $error("result appeared in the cycle after its transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_offset) && $stable(status)
      && $stable(out_coord_0) && $stable(out_coord_1) && $stable(out_coord_2)
      && $stable(out_coord_3)))
    else $error("stalled result changed");

endmodule

bind nd_index_linearizer ndl_checker u_ndl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_offset  (result.out_offset),
  .out_coord_0 (result.out_coord_0),
  .out_coord_1 (result.out_coord_1),
  .out_coord_2 (result.out_coord_2),
  .out_coord_3 (result.out_coord_3),
  .status      (result.status)
);

// ----- tb/nd_index_linearizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_index_linearizer_tb: self-checking bench for the row-major index engine
// Walks a short stimulus table, then runs random phases, each under a new axis
// geometry, and checks every result against a cycle-free model of the array or a hand-typed value.
// ----------------------------------------------------------------------------
module nd_index_linearizer_tb import ndl_pkg::*; ();

  localparam int CYCLE_NS     = 10;
  localparam int RANDOM_ITEMS = 1825;
  localparam int QUIET_ITEMS  = 150;    // tail of the run with no idling
  localparam int SETTLE_TICKS = 100;    // wait after the drain for stray results
  localparam int REPORT_CAP   = 100;

  // Reserved operation codes: the block reports its position and does nothing
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SIZE_1 = REG_AXIS_SIZE_0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SIZE_2 = REG_AXIS_SIZE_0 + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SIZE_3 = REG_AXIS_SIZE_0 + 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_5    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7    = 3'd7;

  typedef logic [0:MAX_AXES-1][AXIS_BITS-1:0] axis_vec_t;
  typedef logic [0:FIELD_AXES-1][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic [OUT_OFF_W-1:0] offset;
    coord_vec_t           coord;
    logic [STATUS_W-1:0]  status;
  } addr_result_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  typed;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [OP_W-1:0]       op;
    coord_vec_t            coord;
    logic [LOFF_W-1:0]     loff;
    addr_result_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  ndl_item_if   item_ch ();
  ndl_result_if result_ch ();
  ndl_cfg_if    cfg_ch ();

  nd_index_linearizer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #(CYCLE_NS / 2) clk = ~clk;

  // Model of the array: geometry registers and the odometer position
  logic [COUNT_W-1:0] geo_count;
  axis_vec_t          geo_size;
  axis_vec_t          odo_pos;

  addr_result_t pending_results [$];
  int           mismatch_count;

  // Stimulus shaping, changed per phase
  bit walk_phase;
  bit quiet;
  int gap_pct;
  int stall_pct;

  // Receiver back-pressure
  bit hold_result;
  int stall_left;

  plan_row_t directed_plan [$];

  assign result_ch.ready = !hold_result;

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  // Clamp the axis count: zero acts as one, anything past the limit as the limit
  function automatic int axes_in_use();
    if (geo_count == 0) return 1;
    if (geo_count > MAX_AXES) return MAX_AXES;
    return int'(geo_count);
  endfunction

  function automatic longint unsigned entry_count();
    longint unsigned total;
    total = 1;
    for (int i = 0; i < axes_in_use(); i++) total = total * geo_size[i];
    return total;
  endfunction

  function automatic logic any_zero(int n);
    for (int i = 0; i < n; i++) if (geo_size[i] == 0) return 1'b1;
    return 1'b0;
  endfunction

  // End position: size-1 on outer axes, the full size on the innermost one.
  // Axes not in use keep whatever the position holds.
  function automatic axis_vec_t end_of_array(int n);
    axis_vec_t e;
    e = odo_pos;
    for (int i = 0; i < n; i++) e[i] = (geo_size[i] != 0) ? geo_size[i] - 1'b1 : '0;
    e[n-1] = geo_size[n-1];
    return e;
  endfunction

  // Row-major offset, innermost axis first. Flag a coordinate above its size
  // or a sum that does not fit the offset width. Four 16-bit sizes never
  // overflow 64 bits, so plain products are exact.
  function automatic logic offset_of(input axis_vec_t c, input int n,
                                     output longint unsigned off);
    longint unsigned stride;
    longint unsigned sum;
    stride = 1;
    sum    = 0;
    off    = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (c[i] > geo_size[i]) return 1'b1;
      sum    = sum + 64'(c[i]) * stride;
      stride = stride * geo_size[i];
    end
    if ((sum >> OFFSET_BITS) != 0) return 1'b1;
    off = sum;
    return 1'b0;
  endfunction

  function automatic addr_result_t predict_address(logic [OP_W-1:0] op, coord_vec_t given_c,
                                                   logic [LOFF_W-1:0] given_off);
    addr_result_t    r;
    axis_vec_t       c;
    axis_vec_t       t;
    longint unsigned off;
    longint unsigned rest;
    longint unsigned stride;
    int              n;
    logic            bad;
    logic            carried;
    logic            done;
    logic            underflow;
    n         = axes_in_use();
    c         = '0;
    off       = 0;
    underflow = 1'b0;
    r.status  = ST_OK;
    if (op == OP_TO_OFFSET) begin
      for (int i = 0; i < n; i++) c[i] = AXIS_BITS'(given_c[i]);
      if (offset_of(c, n, off)) begin
        r.status = ST_RANGE;
        off      = 0;
      end
    end else if (op == OP_TO_COORD) begin
      // Offset is echoed; coordinates stay zero when it is past the last entry
      off = given_off;
      if (off >= entry_count()) begin
        r.status = ST_RANGE;
      end else begin
        rest = off;
        for (int i = 0; i < n; i++) begin
          stride = 1;
          for (int j = i + 1; j < n; j++) stride = stride * geo_size[j];
          c[i] = AXIS_BITS'(rest / stride);
          rest = rest % stride;
        end
      end
    end else begin
      // Odometer; reserved codes fall through and only report the position
      if (op == OP_BEGIN) begin
        odo_pos = '0;
        if (any_zero(n)) odo_pos = end_of_array(n);
      end else if (op == OP_FWD) begin
        if (any_zero(n) || odo_pos == end_of_array(n)) begin
          odo_pos = end_of_array(n);
        end else begin
          carried = 1'b1;
          for (int a = n - 1; a >= 0 && carried; a--) begin
            odo_pos[a] = odo_pos[a] + 1'b1;
            if (odo_pos[a] != geo_size[a]) carried = 1'b0;
            else odo_pos[a] = '0;
          end
          // Carry out of the outermost axis lands on the end position
          if (carried) odo_pos = end_of_array(n);
        end
      end else if (op == OP_BACK) begin
        if (any_zero(n)) begin
          underflow = 1'b1;
        end else begin
          t    = odo_pos;
          done = 1'b0;
          for (int a = n - 1; a >= 0 && !done; a--) begin
            if (t[a] != 0) begin
              t[a] = t[a] - 1'b1;
              done = 1'b1;
            end else begin
              t[a] = geo_size[a] - 1'b1;
            end
          end
          // Stepping back from the start leaves the position alone
          if (done) odo_pos = t;
          else underflow = 1'b1;
        end
      end
      for (int i = 0; i < n; i++) c[i] = odo_pos[i];
      bad = offset_of(c, n, off);
      if (bad) off = 0;
      if (underflow) r.status = ST_BEFORE;
      else if (bad) r.status = ST_RANGE;
      else if (odo_pos == end_of_array(n)) r.status = ST_END;
      else r.status = ST_OK;
    end
    r.offset = OUT_OFF_W'(off);
    for (int i = 0; i < FIELD_AXES; i++) r.coord[i] = COORD_W'(c[i]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus table helpers
  // --------------------------------------------------------------------------

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic plan_row_t item_row(logic [OP_W-1:0] op, logic [COORD_W-1:0] c0,
                                         logic [COORD_W-1:0] c1, logic [COORD_W-1:0] c2,
                                         logic [COORD_W-1:0] c3, logic [LOFF_W-1:0] loff);
    plan_row_t row;
    row          = '0;
    row.kind     = ROW_ITEM;
    row.op       = op;
    row.coord[0] = c0;
    row.coord[1] = c1;
    row.coord[2] = c2;
    row.coord[3] = c3;
    row.loff     = loff;
    return row;
  endfunction

  // Item whose result is typed in by hand
  function automatic plan_row_t known_row(logic [OP_W-1:0] op, logic [COORD_W-1:0] c0,
                                          logic [COORD_W-1:0] c1, logic [COORD_W-1:0] c2,
                                          logic [COORD_W-1:0] c3, logic [LOFF_W-1:0] loff,
                                          logic [OUT_OFF_W-1:0] w_off,
                                          logic [COORD_W-1:0] w0, logic [COORD_W-1:0] w1,
                                          logic [COORD_W-1:0] w2, logic [COORD_W-1:0] w3,
                                          logic [STATUS_W-1:0] w_status);
    plan_row_t row;
    row               = item_row(op, c0, c1, c2, c3, loff);
    row.typed         = 1'b1;
    row.want.offset   = w_off;
    row.want.coord[0] = w0;
    row.want.coord[1] = w1;
    row.want.coord[2] = w2;
    row.want.coord[3] = w3;
    row.want.status   = w_status;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers: drive at the falling edge, sample at the rising edge
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Hold valid until the transfer, then log what the block should answer
  task automatic send_item(input logic [OP_W-1:0] op, input coord_vec_t c,
                           input logic [LOFF_W-1:0] loff, input logic typed,
                           input addr_result_t typed_want);
    addr_result_t predicted;
    item_ch.op            = op;
    item_ch.coord_0       = c[0];
    item_ch.coord_1       = c[1];
    item_ch.coord_2       = c[2];
    item_ch.coord_3       = c[3];
    item_ch.linear_offset = loff;
    item_ch.valid         = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predicted = predict_address(op, c, loff);
    if (typed) predicted = typed_want;
    pending_results.insert(pending_results.size(), predicted);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index = index;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (index == REG_AXIS_COUNT) begin
      geo_count = data[COUNT_W-1:0];
    end else if (index >= REG_AXIS_SIZE_0 && index < REG_AXIS_SIZE_0 + MAX_AXES) begin
      geo_size[index - REG_AXIS_SIZE_0] = AXIS_BITS'(data);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Every item gives a result, so an empty queue means the block is idle
  task automatic wait_idle();
    item_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Pick a geometry: mostly small arrays so walks reach the end, with empty
  // axes, wide axes, odd axis counts and raw register data mixed in
  task automatic choose_geometry();
    int                    mode;
    int                    hi;
    logic [CFG_DATA_W-1:0] d;
    mode = $urandom_range(0, 9);
    if (mode == 8) d = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(5, 7));
    else if (mode == 9) d = 16'($urandom);
    else d = 16'($urandom_range(1, MAX_AXES));
    write_register(REG_AXIS_COUNT, d);
    for (int a = 0; a < MAX_AXES; a++) begin
      if (mode == 7) begin
        d = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'($urandom);
      end else if (mode == 9) begin
        d = 16'($urandom);
      end else begin
        hi = (mode == 6) ? 40 : 4;
        d  = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, hi));
      end
      // Skip some writes so stale positions can fall outside the new sizes
      if (mode >= 7 || $urandom_range(0, 4) != 0)
        write_register(REG_AXIS_SIZE_0 + CFG_IDX_W'(a), d);
    end
    if ($urandom_range(0, 9) == 0)
      write_register(REG_UNUSED_5 + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
  endtask

  task automatic pick_item(output logic [OP_W-1:0] op, output coord_vec_t c,
                           output logic [LOFF_W-1:0] loff);
    int                 r;
    int                 q;
    longint unsigned    total;
    logic [COORD_W-1:0] s;
    r = $urandom_range(0, 99);
    if (walk_phase) begin
      if (r < 70) op = OP_FWD;
      else if (r < 80) op = OP_BACK;
      else if (r < 83) op = OP_BEGIN;
      else if (r < 90) op = OP_TO_OFFSET;
      else if (r < 97) op = OP_TO_COORD;
      else op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
    end else begin
      if (r < 30) op = OP_FWD;
      else if (r < 40) op = OP_BACK;
      else if (r < 45) op = OP_BEGIN;
      else if (r < 70) op = OP_TO_OFFSET;
      else if (r < 95) op = OP_TO_COORD;
      else op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
    end
    // Fields the op ignores carry noise
    loff = $urandom;
    for (int a = 0; a < FIELD_AXES; a++) c[a] = COORD_W'($urandom);
    if (op == OP_TO_OFFSET) begin
      for (int a = 0; a < MAX_AXES; a++) begin
        s = geo_size[a];
        q = $urandom_range(0, 19);
        if (q < 14) c[a] = COORD_W'($urandom_range(0, s));
        else if (q < 17) c[a] = s + 1'b1;
      end
    end else if (op == OP_TO_COORD) begin
      total = entry_count();
      q     = $urandom_range(0, 19);
      if (q < 14 && total != 0) loff = LOFF_W'(64'($urandom) % total);
      else if (q < 16) loff = LOFF_W'(total - 64'(q - 14));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall in random bursts, none in the quiet tail
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      hold_result <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      hold_result <= 1'b1;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      hold_result <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each result transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    addr_result_t got;
    addr_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready) begin
      got.offset   = result_ch.out_offset;
      got.coord[0] = result_ch.out_coord_0;
      got.coord[1] = result_ch.out_coord_1;
      got.coord[2] = result_ch.out_coord_2;
      got.coord[3] = result_ch.out_coord_3;
      got.status   = result_ch.status;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: offset %h status %0d",
                                got.offset, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.offset !== want.offset)
          flag_mismatch($sformatf("out_offset %h, expected %h", got.offset, want.offset));
        for (int a = 0; a < FIELD_AXES; a++) begin
          if (got.coord[a] !== want.coord[a])
            flag_mismatch($sformatf("out_coord_%0d %h, expected %h",
                                    a, got.coord[a], want.coord[a]));
        end
        if (got.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [OP_W-1:0]   op;
    coord_vec_t        c;
    logic [LOFF_W-1:0] loff;
    int                sent;
    int                span;

    // Drive every input to a known value before the first edge
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.op            = OP_TO_OFFSET;
    item_ch.coord_0       = '0;
    item_ch.coord_1       = '0;
    item_ch.coord_2       = '0;
    item_ch.coord_3       = '0;
    item_ch.linear_offset = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_AXIS_COUNT;
    cfg_ch.data           = '0;
    mismatch_count        = 0;
    quiet                 = 1'b0;
    walk_phase            = 1'b0;
    gap_pct               = 0;
    stall_pct             = 25;

    // Register state after reset: one axis of size one, position at zero
    geo_count = 3'd1;
    for (int a = 0; a < MAX_AXES; a++) geo_size[a] = 16'd1;
    odo_pos = '0;

    // Directed table. With one axis of size one, the end position is 1.
    directed_plan = '{
      known_row(OP_BEGIN,     0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_OK),
      // full carry out of the only axis lands on the end position
      known_row(OP_FWD,       0, 0, 0, 0, 0,   1, 1, 0, 0, 0, ST_END),
      // forward at the end stays put
      known_row(OP_FWD,       0, 0, 0, 0, 0,   1, 1, 0, 0, 0, ST_END),
      known_row(OP_BACK,      0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_OK),
      // back from the start
      known_row(OP_BACK,      0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_BEFORE),
      // coordinate equal to its size maps; unused axes read as zero
      known_row(OP_TO_OFFSET, 1, 16'hffff, 16'hffff, 16'hffff, 0,
                1, 1, 0, 0, 0, ST_OK),
      known_row(OP_TO_OFFSET, 16'hffff, 0, 0, 0, 32'hffff_ffff,
                0, 16'hffff, 0, 0, 0, ST_RANGE),
      known_row(OP_TO_COORD,  0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_OK),
      known_row(OP_TO_COORD,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff,
                32'hffff_ffff, 0, 0, 0, 0, ST_RANGE),
      known_row(OP_RSVD_5,    16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff,
                0, 0, 0, 0, 0, ST_OK),
      known_row(OP_RSVD_7,    0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_OK),
      // four axes, 3 x 4 x 5 x 6 = 360 entries
      reg_row(REG_AXIS_COUNT, 16'd4),
      reg_row(REG_AXIS_SIZE_0, 16'd3),
      reg_row(REG_AXIS_SIZE_1, 16'd4),
      reg_row(REG_AXIS_SIZE_2, 16'd5),
      reg_row(REG_AXIS_SIZE_3, 16'd6),
      item_row(OP_TO_OFFSET, 3, 4, 5, 6, 0),
      known_row(OP_TO_OFFSET, 2, 3, 4, 7, 0,   0, 2, 3, 4, 7, ST_RANGE),
      item_row(OP_TO_COORD,  0, 0, 0, 0, 359),
      known_row(OP_TO_COORD,  0, 0, 0, 0, 360, 360, 0, 0, 0, 0, ST_RANGE),
      item_row(OP_BEGIN,     0, 0, 0, 0, 0),
      known_row(OP_BACK,      0, 0, 0, 0, 0,   0, 0, 0, 0, 0, ST_BEFORE),
      // empty array: begin and forward go to the end, back underflows
      reg_row(REG_AXIS_SIZE_2, 16'd0),
      item_row(OP_BEGIN,     0, 0, 0, 0, 0),
      item_row(OP_FWD,       0, 0, 0, 0, 0),
      item_row(OP_BACK,      0, 0, 0, 0, 0),
      // shrink the innermost axis under the stored position
      reg_row(REG_AXIS_SIZE_3, 16'd4),
      reg_row(REG_AXIS_SIZE_2, 16'd2),
      item_row(OP_RSVD_6,    0, 0, 0, 0, 0),
      item_row(OP_FWD,       0, 0, 0, 0, 0),
      item_row(OP_BACK,      0, 0, 0, 0, 0),
      // axis count zero acts as one
      reg_row(REG_AXIS_COUNT, 16'd0),
      item_row(OP_TO_OFFSET, 3, 16'hffff, 0, 16'hffff, 0),
      // count field seven acts as four; widest axes overflow the offset
      reg_row(REG_AXIS_COUNT, 16'hffff),
      reg_row(REG_AXIS_SIZE_0, 16'hffff),
      reg_row(REG_AXIS_SIZE_1, 16'hffff),
      reg_row(REG_AXIS_SIZE_2, 16'hffff),
      reg_row(REG_AXIS_SIZE_3, 16'hffff),
      known_row(OP_TO_OFFSET, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0,
                0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, ST_RANGE),
      item_row(OP_TO_COORD,  0, 0, 0, 0, 32'hffff_ffff),
      reg_row(REG_UNUSED_7, 16'hffff)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the table; let the block go idle before each register write
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_register(directed_plan[i].index, directed_plan[i].data);
      end else begin
        send_item(directed_plan[i].op, directed_plan[i].coord, directed_plan[i].loff,
                  directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases. Each one starts by draining every outstanding result,
    // which doubles as the sender pause under pressure.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      choose_geometry();
      walk_phase = ($urandom_range(0, 1) != 0);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 40;
      endcase
      span = $urandom_range(30, 120);
      for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          item_ch.valid = 1'b0;
          repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pick_item(op, c, loff);
        send_item(op, c, loff, 1'b0, '0);
        sent++;
      end
    end
    item_ch.valid = 1'b0;

    // Drain, then give stray results time to show up
    for (int w = 0; w < 4000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("nd_index_linearizer regression: pass");
    end else begin
      $display("nd_index_linearizer regression: fail");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #(CYCLE_NS * 1_000_000);
    $display("nd_index_linearizer regression: fail");
    $finish;
  end

endmodule
